/* rtl/cholesky_decomposition_top_macros.svh */
// Assertion macros for the Cholesky factorization block.
// Used by the controller and the top level; no other dependencies.
`ifndef CHOLESKY_DECOMPOSITION_TOP_MACROS_SVH
`define CHOLESKY_DECOMPOSITION_TOP_MACROS_SVH
`ifndef SYNTH
`define CHK_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("check failed");
`define CHK_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("check failed");
`else
`define CHK_IMPLY(label, clk, rst, a, b)
`define CHK_NEXT(label, clk, rst, a, b)
`endif
`endif

/* rtl/chol_pkg.sv */
// Package for the Cholesky factorization block: sizes, state and command types.
// No dependencies.
`default_nettype none
package chol_pkg;
  localparam int MaxSize = 8;
  localparam int FracBits = 16;
  localparam int TriDepth = MaxSize * (MaxSize + 1) / 2;
  localparam int AddrW = $clog2(TriDepth);
  localparam int IdxW = 3;

  typedef enum logic [4:0] {
    ST_IDLE, ST_START, ST_ELEM, ST_MAC_RD, ST_MAC_RD2, ST_MAC_ACC, ST_MAC_MUL,
    ST_SUB_RD, ST_SUB, ST_CHECK, ST_SQRT, ST_DIV, ST_WRITE, ST_NEXT,
    ST_EMIT_RD, ST_EMIT_WAIT, ST_EMIT, ST_FAIL
  } state_t;

  typedef struct packed {
    logic [AddrW-1:0] raddr;
    logic             rd_a;
    logic             rd_b;
    logic             mul;
    logic             acc_clr;
    logic             acc_add;
    logic             sub;
    logic             sqrt_start;
    logic             div_start;
    logic             wr_sqrt;
    logic [AddrW-1:0] waddr;
    logic             wr;
  } dp_cmd_t;

  typedef struct packed {
    logic        busy;
    logic        v_nonpos;
    logic [31:0] rdata;
  } dp_stat_t;

  function automatic logic [AddrW-1:0] tri_idx(input logic [IdxW-1:0] r,
                                              input logic [IdxW-1:0] c);
    logic [AddrW:0] rr;
    rr = {{(AddrW+1-IdxW){1'b0}}, r};
    tri_idx = AddrW'(((rr * (rr + 1'b1)) >> 1) + {{(AddrW+1-IdxW){1'b0}}, c});
  endfunction
endpackage
`default_nettype wire

/* rtl/chol_dp.sv */
// Datapath: input and factor stores, multiplier, accumulator, root and divider units.
// Depends on chol_pkg.
`default_nettype none
module chol_dp import chol_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            ld_we,
  input  wire logic [AddrW-1:0] ld_addr,
  input  wire logic [31:0]     ld_data,
  input  wire dp_cmd_t         cmd,
  output dp_stat_t             stat
);
  logic [31:0] in_mem [TriDepth];
  logic [31:0] f_mem [TriDepth];
  logic [31:0] in_rd, f_rd, opa, opb, v, result;
  logic signed [63:0] prod, acc;
  logic signed [31:0] pterm;
  logic [63:0] sq_x, sq_res, sq_bit;
  logic [63:0] dv_rem;
  logic [47:0] dv_num;
  logic [31:0] dv_den;
  logic [48:0] dv_q;
  logic        dv_neg;
  logic [5:0]  cnt;
  logic        busy;
  logic signed [64:0] diff;
  logic signed [63:0] shr;
  logic [63:0] nrem;

  always_ff @(posedge clk) begin
    if (ld_we) in_mem[ld_addr] <= ld_data;
    if (cmd.wr) f_mem[cmd.waddr] <= result;
    in_rd <= in_mem[cmd.raddr];
    f_rd <= f_mem[cmd.raddr];
  end

  function automatic logic signed [31:0] sat(input logic signed [64:0] x);
    if (x > 65'sh7FFFFFFF) sat = 32'sh7FFFFFFF;
    else if (x < -65'sh80000000) sat = 32'sh80000000;
    else sat = x[31:0];
  endfunction

  always_comb begin
    shr = prod >>> FracBits;
    pterm = sat({shr[63], shr});
    diff = {{33{in_rd[31]}}, in_rd} - {acc[63], acc};
    nrem = {dv_rem[62:0], dv_num[47]};
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_a) opa <= f_rd;
    if (cmd.rd_b) opb <= f_rd;
    if (cmd.mul) prod <= $signed(opa) * $signed(opb);
    if (cmd.acc_clr) acc <= '0;
    else if (cmd.acc_add) acc <= acc + {{32{pterm[31]}}, pterm};
    if (cmd.sub) v <= sat(diff);
    if (cmd.rd_b && !cmd.rd_a) dv_den <= f_rd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (cmd.sqrt_start) begin
      busy <= 1'b1;
      cnt <= 6'd32;
      sq_x <= {32'd0, v} << FracBits;
      sq_res <= '0;
      sq_bit <= 64'd1 << 62;
    end else if (cmd.div_start) begin
      busy <= 1'b1;
      cnt <= 6'd48;
      dv_neg <= v[31];
      dv_num <= {(v[31] ? 32'd0 - v : v), 16'd0};
      dv_rem <= '0;
      dv_q <= '0;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == 6'd1) busy <= 1'b0;
      if (cmd.wr_sqrt) begin
        if (sq_x >= sq_res + sq_bit) begin
          sq_x <= sq_x - (sq_res + sq_bit);
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end else begin
        dv_num <= dv_num << 1;
        if (nrem >= {32'd0, dv_den}) begin
          dv_rem <= nrem - {32'd0, dv_den};
          dv_q <= {dv_q[47:0], 1'b1};
        end else begin
          dv_rem <= nrem;
          dv_q <= {dv_q[47:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    if (cmd.wr_sqrt) result = sq_res[31:0];
    else if (dv_neg) result = (dv_q > 49'h80000000) ? 32'h80000000 : 32'd0 - dv_q[31:0];
    else result = (dv_q > 49'h7FFFFFFF) ? 32'h7FFFFFFF : dv_q[31:0];
  end

  assign stat.busy = busy;
  assign stat.v_nonpos = v[31] || (v == 32'd0);
  assign stat.rdata = f_rd;
endmodule
`default_nettype wire

/* rtl/chol_ctrl.sv */
// Controller: sequences the factorization loops and the output of the factor.
// Depends on chol_pkg and the assertion macros.
`default_nettype none
`include "cholesky_decomposition_top_macros.svh"
module chol_ctrl import chol_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [3:0]      size,
  input  wire dp_stat_t        stat,
  input  wire logic            o_ready,
  output dp_cmd_t              cmd,
  output logic                 idle,
  output logic                 o_valid,
  output logic [IdxW-1:0]      o_row,
  output logic [IdxW-1:0]      o_col,
  output logic [31:0]          o_value,
  output logic                 o_status,
  output logic                 o_last
);
  state_t state, state_next;
  logic [IdxW-1:0] i, j, k, i_next, j_next, k_next, nm1;
  logic [3:0] n;

  always_comb begin
    n = (size == 4'd0) ? 4'd1 : (size > 4'(MaxSize)) ? 4'(MaxSize) : size;
    nm1 = IdxW'(n - 4'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      i <= '0; j <= '0; k <= '0;
    end else begin
      state <= state_next;
      i <= i_next; j <= j_next; k <= k_next;
    end
  end

  always_comb begin
    state_next = state;
    i_next = i; j_next = j; k_next = k;
    cmd = '0;
    idle = 1'b0;
    o_valid = 1'b0;
    o_status = 1'b0;
    o_last = 1'b0;
    o_row = i;
    o_col = j;
    o_value = stat.rdata;
    case (state)
      ST_IDLE: begin
        idle = 1'b1;
        if (start) begin
          state_next = ST_ELEM;
          i_next = '0; j_next = '0; k_next = '0;
        end
      end
      ST_ELEM: begin
        cmd.acc_clr = 1'b1;
        k_next = '0;
        state_next = (j == '0) ? ST_SUB_RD : ST_MAC_RD;
      end
      ST_MAC_RD: begin
        cmd.raddr = tri_idx(i, k);
        state_next = ST_MAC_RD2;
      end
      ST_MAC_RD2: begin
        cmd.rd_a = 1'b1;
        cmd.raddr = tri_idx(j, k);
        state_next = ST_MAC_MUL;
      end
      ST_MAC_MUL: begin
        cmd.rd_b = 1'b1;
        cmd.raddr = tri_idx(j, k);
        state_next = ST_START;
      end
      ST_START: begin
        cmd.mul = 1'b1;
        state_next = ST_MAC_ACC;
      end
      ST_MAC_ACC: begin
        cmd.acc_add = 1'b1;
        k_next = k + 1'b1;
        state_next = (k + 1'b1 == j) ? ST_SUB_RD : ST_MAC_RD;
      end
      ST_SUB_RD: begin
        cmd.raddr = tri_idx(i, j);
        state_next = ST_SUB;
      end
      ST_SUB: begin
        cmd.sub = 1'b1;
        cmd.raddr = tri_idx(j, j);
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.raddr = tri_idx(j, j);
        if (i == j) begin
          if (stat.v_nonpos) state_next = ST_FAIL;
          else begin
            cmd.sqrt_start = 1'b1;
            state_next = ST_SQRT;
          end
        end else begin
          cmd.rd_b = 1'b1;
          state_next = ST_NEXT;
        end
      end
      ST_NEXT: begin
        cmd.div_start = 1'b1;
        state_next = ST_DIV;
      end
      ST_SQRT: begin
        cmd.wr_sqrt = 1'b1;
        if (!stat.busy) state_next = ST_WRITE;
      end
      ST_DIV: begin
        if (!stat.busy) state_next = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.wr = 1'b1;
        cmd.wr_sqrt = (i == j);
        cmd.waddr = tri_idx(i, j);
        if (j == i) begin
          j_next = '0;
          i_next = i + 1'b1;
          if (i == nm1) begin
            state_next = ST_EMIT_RD;
            i_next = '0;
          end else state_next = ST_ELEM;
        end else begin
          j_next = j + 1'b1;
          state_next = ST_ELEM;
        end
      end
      ST_EMIT_RD: begin
        cmd.raddr = tri_idx(i, j);
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.raddr = tri_idx(i, j);
        o_valid = 1'b1;
        o_last = (i == nm1) && (j == i);
        if (o_ready) begin
          if (j == i) begin
            j_next = '0;
            i_next = i + 1'b1;
            state_next = (i == nm1) ? ST_IDLE : ST_EMIT_RD;
          end else begin
            j_next = j + 1'b1;
            state_next = ST_EMIT_RD;
          end
        end
      end
      ST_FAIL: begin
        o_valid = 1'b1;
        o_status = 1'b1;
        o_last = 1'b1;
        o_row = '0;
        o_col = '0;
        o_value = '0;
        if (o_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `CHK_IMPLY(a_col_le_row, clk, rst, o_valid, o_col <= o_row)
  `CHK_IMPLY(a_fail_zero, clk, rst, o_valid && o_status, o_value == 32'd0 && o_last)
  `CHK_NEXT(a_last_done, clk, rst, o_valid && o_ready && o_last, state == ST_IDLE)
endmodule
`default_nettype wire

/* rtl/cholesky_decomposition_top.sv */
// Top level of the Cholesky factorization block: stream ports and config register.
// Depends on chol_pkg, chol_ctrl, chol_dp and the assertion macros.
`default_nettype none
// Loads the lower triangle one transfer per cycle while idle; the transfer with
// tlast starts the factorization into the separate factor store, and input is refused
// from the cycle after it. Each factor entry takes one multiply-accumulate per
// earlier column, then a read, subtract and check, then a bit-serial root per
// diagonal entry or a restoring division per off-diagonal entry, then write-back;
// results then leave one at a time, each read before it is offered and held
// until taken. Inputs are refused until the run's last result is taken.
`include "cholesky_decomposition_top_macros.svh"
module cholesky_decomposition_top import chol_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,  // row_index[2:0], col_index[5:3], element_value[37:6]
  input  wire logic        s_tlast,  // load_last
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,  // out_row[2:0], out_col[5:3], factor_value[37:6]
  output logic             m_tuser,  // status
  output logic             m_tlast   // run_last
);
  logic [3:0] size;
  logic idle, in_fire, start;
  logic [2:0] r, c, orow, ocol;
  logic [31:0] oval;
  dp_cmd_t cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) size <= 4'd8;
    else if (cfg_valid) size <= cfg_data;
  end

  assign r = s_tdata[2:0];
  assign c = s_tdata[5:3];
  assign s_tready = idle && !start;
  assign in_fire = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) start <= 1'b0;
    else start <= in_fire && s_tlast;
  end

  chol_dp u_dp (
    .clk(clk), .rst(rst),
    .ld_we(in_fire && (c <= r)),
    .ld_addr(tri_idx(r, c)),
    .ld_data(s_tdata[37:6]),
    .cmd(cmd), .stat(stat)
  );

  chol_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .size(size), .stat(stat),
    .o_ready(m_tready), .cmd(cmd), .idle(idle), .o_valid(m_tvalid),
    .o_row(orow), .o_col(ocol), .o_value(oval), .o_status(m_tuser), .o_last(m_tlast)
  );

  assign m_tdata = {2'b00, oval, ocol, orow};

  `CHK_IMPLY(a_no_in_busy, clk, rst, m_tvalid, !s_tready)
  `CHK_NEXT(a_start_blocks, clk, rst, in_fire && s_tlast, !s_tready)
  `CHK_IMPLY(a_pad_zero, clk, rst, m_tvalid, m_tdata[39:38] == 2'b00)
endmodule
`default_nettype wire
